/* design/tcbf_pkg.sv */
// Shared types, codes and helper functions of the two-color block framebuffer.
package tcbf_pkg;

  // Fixed field widths
  localparam int PIX_XW   = 9;
  localparam int PIX_YW   = 8;
  localparam int COLOR_W  = 16;
  localparam int LEVEL_W  = 10;
  localparam int BCOL_W   = 6;
  localparam int BROW_W   = 5;
  localparam int CFG_W    = 10;
  localparam int CFG_IDXW = 2;

  // Brightness threshold after reset
  localparam logic [LEVEL_W-1:0] FRONT_LEVEL_RESET = 10'd384;

  // Shift of the reciprocal multiply that replaces division by a small constant
  localparam int RCP_SHIFT = 20;

  // Item kinds
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDXW-1:0] CFG_USED_WIDTH  = 2'd0;
  localparam logic [CFG_IDXW-1:0] CFG_USED_HEIGHT = 2'd1;
  localparam logic [CFG_IDXW-1:0] CFG_FRONT_LEVEL = 2'd2;

  // Side information that travels with a pixel address through the pipeline
  typedef struct packed {
    logic               flush;
    logic               last;
    logic               front;
    logic [COLOR_W-1:0] color;
  } tcbf_tag_t;

  // Sum of the channels expanded to 8 bits
  function automatic logic [LEVEL_W-1:0] brightness(input logic [COLOR_W-1:0] c);
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
    r = {2'b00, c[4:0], 3'b000};
    g = {2'b00, c[10:5], 2'b00};
    b = {2'b00, c[15:11], 3'b000};
    return r + g + b;
  endfunction

  // Channel expansion and reduction back to RGB565 is the identity; swap bytes
  function automatic logic [COLOR_W-1:0] out_color(input logic [COLOR_W-1:0] c);
    return {c[7:0], c[15:8]};
  endfunction

endpackage

/* design/tcbf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tcbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* design/tcbf_addr.sv */
// Two-stage address unit: pixel, cell and block indexes from a pixel position.
module tcbf_addr
  import tcbf_pkg::*;
#(
  parameter int SCREEN_WIDTH     = 320,
  parameter int SCREEN_HEIGHT    = 240,
  parameter int CELL_WIDTH       = 8,
  parameter int CELL_HEIGHT      = 8,
  parameter int OUT_BLOCK_WIDTH  = 8,
  parameter int OUT_BLOCK_HEIGHT = 8,
  localparam int CELLS_X  = (SCREEN_WIDTH + CELL_WIDTH - 1) / CELL_WIDTH,
  localparam int CELLS_Y  = (SCREEN_HEIGHT + CELL_HEIGHT - 1) / CELL_HEIGHT,
  localparam int BLOCKS_X = SCREEN_WIDTH / OUT_BLOCK_WIDTH,
  localparam int BLOCKS_Y = SCREEN_HEIGHT / OUT_BLOCK_HEIGHT,
  localparam int PIX_DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT,
  localparam int CELL_DEPTH = CELLS_X * CELLS_Y,
  localparam int BLK_DEPTH  = BLOCKS_X * BLOCKS_Y,
  localparam int XW  = $clog2(SCREEN_WIDTH),
  localparam int YW  = $clog2(SCREEN_HEIGHT),
  localparam int PAW = $clog2(PIX_DEPTH),
  localparam int CAW = $clog2(CELL_DEPTH),
  localparam int BAW = $clog2(BLK_DEPTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [XW-1:0]  x_i,
  input  logic [YW-1:0]  y_i,
  input  tcbf_tag_t      tag_i,
  output logic           valid_o,
  output logic           busy_o,
  output tcbf_tag_t      tag_o,
  output logic [PAW-1:0] paddr_o,
  output logic [CAW-1:0] cell_o,
  output logic [BAW-1:0] bidx_o,
  output logic           bok_o
);

  localparam int CXW = (CELLS_X > 1) ? $clog2(CELLS_X) : 1;
  localparam int CYW = (CELLS_Y > 1) ? $clog2(CELLS_Y) : 1;
  localparam int RCX = ((1 << RCP_SHIFT) + CELL_WIDTH - 1) / CELL_WIDTH;
  localparam int RCY = ((1 << RCP_SHIFT) + CELL_HEIGHT - 1) / CELL_HEIGHT;
  localparam int RBX = ((1 << RCP_SHIFT) + OUT_BLOCK_WIDTH - 1) / OUT_BLOCK_WIDTH;
  localparam int RBY = ((1 << RCP_SHIFT) + OUT_BLOCK_HEIGHT - 1) / OUT_BLOCK_HEIGHT;

  // First stage: quotients by reciprocal multiply, row offset
  logic            v1_q;
  tcbf_tag_t       tag1_q;
  logic [XW-1:0]   x1_q;
  logic [PAW-1:0]  yw1_q;
  logic [CXW-1:0]  qcx1_q;
  logic [CYW-1:0]  qcy1_q;
  logic [XW-1:0]   qbx1_q;
  logic [YW-1:0]   qby1_q;
  logic            bok1_q;

  int qbx_full;
  int qby_full;

  always_comb begin
    qbx_full = (int'(x_i) * RBX) >> RCP_SHIFT;
    qby_full = (int'(y_i) * RBY) >> RCP_SHIFT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag1_q <= tag_i;
      x1_q   <= x_i;
      yw1_q  <= PAW'(int'(y_i) * SCREEN_WIDTH);
      qcx1_q <= CXW'((int'(x_i) * RCX) >> RCP_SHIFT);
      qcy1_q <= CYW'((int'(y_i) * RCY) >> RCP_SHIFT);
      qbx1_q <= XW'(qbx_full);
      qby1_q <= YW'(qby_full);
      bok1_q <= (qbx_full < BLOCKS_X) && (qby_full < BLOCKS_Y);
    end
  end

  // Second stage: flat indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_o   <= tag1_q;
      paddr_o <= PAW'(int'(yw1_q) + int'(x1_q));
      cell_o  <= CAW'(int'(qcx1_q) + int'(qcy1_q) * CELLS_X);
      bidx_o  <= BAW'(int'(qbx1_q) + int'(qby1_q) * BLOCKS_X);
      bok_o   <= bok1_q;
    end
  end

  assign busy_o = v1_q | valid_o;

endmodule

/* design/two_color_block_framebuffer.sv */
// Top level of the two-color block framebuffer: control, memories and output register.
//
// Usage: items enter on the in_valid_i/in_ready_o channel, results leave on
// out_valid_o/out_ready_i. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while the block is
// idle, the block itself does not enforce this. A set-pixel item passes two
// address stages, a memory read, and a write back of pixel bit, cell color
// and dirty count. A flush item reads the dirty count, then streams the
// block one pixel per cycle while the output is not stalled, through the
// address stages and the memory read. A skipped flush gives its one result.
// A clear item, and reset, run a fill pass over the pixel-bit and cell-color
// memories, one entry per cycle, during which no item is accepted. Reset
// also zeros the dirty counts in the same pass; the first clear sets them
// to one. When the receiver stalls, the output register holds its
// transaction and the whole pipeline, including the memory reads, freezes
// until it is taken.
module two_color_block_framebuffer
  import tcbf_pkg::*;
#(
  parameter int SCREEN_WIDTH     = 320,
  parameter int SCREEN_HEIGHT    = 240,
  parameter int CELL_WIDTH       = 8,
  parameter int CELL_HEIGHT      = 8,
  parameter int OUT_BLOCK_WIDTH  = 8,
  parameter int OUT_BLOCK_HEIGHT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IDXW-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [PIX_XW-1:0]   pixel_x_i,
  input  logic [PIX_YW-1:0]   pixel_y_i,
  input  logic [COLOR_W-1:0]  color_in_i,
  input  logic [BCOL_W-1:0]   block_col_i,
  input  logic [BROW_W-1:0]   block_row_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [COLOR_W-1:0]  pixel_out_o,
  output logic                block_skipped_o,
  output logic                last_o
);

  localparam int CELLS_X    = (SCREEN_WIDTH + CELL_WIDTH - 1) / CELL_WIDTH;
  localparam int CELLS_Y    = (SCREEN_HEIGHT + CELL_HEIGHT - 1) / CELL_HEIGHT;
  localparam int BLOCKS_X   = SCREEN_WIDTH / OUT_BLOCK_WIDTH;
  localparam int BLOCKS_Y   = SCREEN_HEIGHT / OUT_BLOCK_HEIGHT;
  localparam int PIX_DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int CELL_DEPTH = CELLS_X * CELLS_Y;
  localparam int BLK_DEPTH  = BLOCKS_X * BLOCKS_Y;
  localparam int XW  = $clog2(SCREEN_WIDTH);
  localparam int YW  = $clog2(SCREEN_HEIGHT);
  localparam int PAW = $clog2(PIX_DEPTH);
  localparam int CAW = $clog2(CELL_DEPTH);
  localparam int BAW = $clog2(BLK_DEPTH);
  localparam int IW  = (OUT_BLOCK_WIDTH > 1) ? $clog2(OUT_BLOCK_WIDTH) : 1;
  localparam int JW  = (OUT_BLOCK_HEIGHT > 1) ? $clog2(OUT_BLOCK_HEIGHT) : 1;

  typedef enum logic [6:0] {
    ST_SWEEP  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SET    = 7'b0000100,
    ST_DEC    = 7'b0001000,
    ST_SKIP   = 7'b0010000,
    ST_STREAM = 7'b0100000,
    ST_DRAIN  = 7'b1000000
  } state_e;

  // Configuration registers
  logic [PIX_XW-1:0]  used_width_q;
  logic [PIX_YW-1:0]  used_height_q;
  logic [LEVEL_W-1:0] front_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_width_q  <= PIX_XW'(SCREEN_WIDTH);
      used_height_q <= PIX_YW'(SCREEN_HEIGHT);
      front_level_q <= FRONT_LEVEL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_USED_WIDTH: begin
          if (int'(cfg_data_i[PIX_XW-1:0]) <= SCREEN_WIDTH) begin
            used_width_q <= cfg_data_i[PIX_XW-1:0];
          end
        end
        CFG_USED_HEIGHT: begin
          if (int'(cfg_data_i[PIX_YW-1:0]) <= SCREEN_HEIGHT) begin
            used_height_q <= cfg_data_i[PIX_YW-1:0];
          end
        end
        CFG_FRONT_LEVEL: front_level_q <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Control registers
  state_e         state_q, state_d;
  logic [PAW-1:0] sw_q, sw_d;
  logic           sweep_dirty_q, sweep_dirty_d;
  logic           sweep_dv_q, sweep_dv_d;
  logic           first_done_q, first_done_d;
  logic [IW-1:0]  i_q, i_d;
  logic [JW-1:0]  j_q, j_d;
  logic           fl_ok_q, fl_ok_d;
  logic [BAW-1:0] fl_bidx_q, fl_bidx_d;
  logic [XW-1:0]  fl_x0_q, fl_x0_d;
  logic [YW-1:0]  fl_y0_q, fl_y0_d;
  logic           dbit_q, dbit_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [COLOR_W-1:0] pixel_q, pixel_d;
  logic               skipped_q, skipped_d;
  logic               last_q, last_d;

  // Pipeline
  logic           adv;
  logic           feed_valid;
  logic [XW-1:0]  feed_x;
  logic [YW-1:0]  feed_y;
  tcbf_tag_t      feed_tag;
  logic           av;
  logic           abusy;
  tcbf_tag_t      atag;
  logic [PAW-1:0] apaddr;
  logic [CAW-1:0] acell;
  logic [BAW-1:0] abidx;
  logic           abok;

  logic           v3_q;
  tcbf_tag_t      tag3_q;
  logic [PAW-1:0] paddr3_q;
  logic [CAW-1:0] cell3_q;
  logic [BAW-1:0] bidx3_q;
  logic           bok3_q;

  // Memory ports
  logic           front_we, front_wd, front_rd;
  logic [PAW-1:0] front_wa;
  logic           color_we;
  logic [CAW-1:0] color_wa;
  logic [31:0]    color_wd, color_rd;
  logic           dirty_we, dirty_re;
  logic [BAW-1:0] dirty_wa, dirty_ra;
  logic [1:0]     dirty_wd, dirty_rd;

  // Decode of the incoming transaction
  logic           acc;
  logic           set_in_area;
  logic           blk_ok;
  logic [BAW-1:0] in_bidx;
  logic           stream_last;
  logic           pipe_empty;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && adv;
  assign acc        = in_valid_i && in_ready_o;
  assign pipe_empty = !abusy && !v3_q;

  always_comb begin
    set_in_area = (pixel_x_i < used_width_q) && (pixel_y_i < used_height_q);
    blk_ok = ((int'(block_col_i) + 1) * OUT_BLOCK_WIDTH <= int'(used_width_q)) &&
             ((int'(block_row_i) + 1) * OUT_BLOCK_HEIGHT <= int'(used_height_q)) &&
             (int'(block_col_i) < BLOCKS_X) && (int'(block_row_i) < BLOCKS_Y);
    in_bidx = blk_ok ? BAW'(int'(block_col_i) + int'(block_row_i) * BLOCKS_X) : '0;
    stream_last = (i_q == IW'(OUT_BLOCK_WIDTH - 1)) && (j_q == JW'(OUT_BLOCK_HEIGHT - 1));
  end

  // Feed the address unit from a set-pixel transaction or the flush counters
  always_comb begin
    feed_tag.flush = (state_q == ST_STREAM);
    feed_tag.last  = stream_last;
    feed_tag.front = brightness(color_in_i) >= front_level_q;
    feed_tag.color = color_in_i;
    if (state_q == ST_STREAM) begin
      feed_valid = 1'b1;
      feed_x     = XW'(int'(fl_x0_q) + int'(i_q));
      feed_y     = YW'(int'(fl_y0_q) + int'(j_q));
    end else begin
      feed_valid = acc && (kind_i == KIND_SET) && set_in_area;
      feed_x     = XW'(pixel_x_i);
      feed_y     = YW'(pixel_y_i);
    end
  end

  tcbf_addr #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .CELL_WIDTH      (CELL_WIDTH),
    .CELL_HEIGHT     (CELL_HEIGHT),
    .OUT_BLOCK_WIDTH (OUT_BLOCK_WIDTH),
    .OUT_BLOCK_HEIGHT(OUT_BLOCK_HEIGHT)
  ) u_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(feed_valid),
    .x_i    (feed_x),
    .y_i    (feed_y),
    .tag_i  (feed_tag),
    .valid_o(av),
    .busy_o (abusy),
    .tag_o  (atag),
    .paddr_o(apaddr),
    .cell_o (acell),
    .bidx_o (abidx),
    .bok_o  (abok)
  );

  // Memory-read stage, aligned with the registered RAM data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= av;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag3_q   <= atag;
      paddr3_q <= apaddr;
      cell3_q  <= acell;
      bidx3_q  <= abidx;
      bok3_q   <= abok;
    end
  end

  // Memory write and read port selection
  always_comb begin
    front_we = 1'b0;
    front_wa = paddr3_q;
    front_wd = tag3_q.front;
    color_we = 1'b0;
    color_wa = cell3_q;
    color_wd = tag3_q.front ? {tag3_q.color, color_rd[15:0]} :
                              {color_rd[31:16], tag3_q.color};
    dirty_we = 1'b0;
    dirty_wa = bidx3_q;
    dirty_wd = {1'b1, dirty_rd[0]};
    if (state_q == ST_SWEEP) begin
      front_we = 1'b1;
      front_wa = sw_q;
      front_wd = 1'b1;
      color_we = int'(sw_q) < CELL_DEPTH;
      color_wa = CAW'(sw_q);
      color_wd = '1;
      dirty_we = sweep_dirty_q && (int'(sw_q) < BLK_DEPTH);
      dirty_wa = BAW'(sw_q);
      dirty_wd = {1'b0, sweep_dv_q};
    end else if (state_q == ST_DRAIN) begin
      dirty_we = pipe_empty;
      dirty_wa = fl_bidx_q;
      dirty_wd = {1'b0, dbit_q};
    end else if (v3_q && adv && !tag3_q.flush) begin
      front_we = 1'b1;
      color_we = 1'b1;
      dirty_we = bok3_q;
    end
    dirty_re = (state_q == ST_IDLE) ? 1'b1 : (adv && av);
    dirty_ra = (state_q == ST_IDLE) ? in_bidx : abidx;
  end

  tcbf_ram #(.WIDTH(1), .DEPTH(PIX_DEPTH)) u_front_ram (
    .clk_i  (clk_i),
    .we_i   (front_we),
    .waddr_i(front_wa),
    .wdata_i(front_wd),
    .re_i   (adv && av),
    .raddr_i(apaddr),
    .rdata_o(front_rd)
  );

  tcbf_ram #(.WIDTH(32), .DEPTH(CELL_DEPTH)) u_color_ram (
    .clk_i  (clk_i),
    .we_i   (color_we),
    .waddr_i(color_wa),
    .wdata_i(color_wd),
    .re_i   (adv && av),
    .raddr_i(acell),
    .rdata_o(color_rd)
  );

  tcbf_ram #(.WIDTH(2), .DEPTH(BLK_DEPTH)) u_dirty_ram (
    .clk_i  (clk_i),
    .we_i   (dirty_we),
    .waddr_i(dirty_wa),
    .wdata_i(dirty_wd),
    .re_i   (dirty_re),
    .raddr_i(dirty_ra),
    .rdata_o(dirty_rd)
  );

  // Sequencer
  always_comb begin
    state_d       = state_q;
    sw_d          = sw_q;
    sweep_dirty_d = sweep_dirty_q;
    sweep_dv_d    = sweep_dv_q;
    first_done_d  = first_done_q;
    i_d           = i_q;
    j_d           = j_q;
    fl_ok_d       = fl_ok_q;
    fl_bidx_d     = fl_bidx_q;
    fl_x0_d       = fl_x0_q;
    fl_y0_d       = fl_y0_q;
    dbit_d        = dbit_q;
    unique case (state_q)
      ST_SWEEP: begin
        sw_d = sw_q + PAW'(1);
        if (sw_q == PAW'(PIX_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          unique case (kind_i)
            KIND_SET: begin
              if (set_in_area) begin
                state_d = ST_SET;
              end
            end
            KIND_CLEAR: begin
              state_d       = ST_SWEEP;
              sw_d          = '0;
              sweep_dirty_d = !first_done_q;
              sweep_dv_d    = 1'b1;
              first_done_d  = 1'b1;
            end
            KIND_FLUSH: begin
              state_d   = ST_DEC;
              fl_ok_d   = blk_ok;
              fl_bidx_d = in_bidx;
              fl_x0_d   = XW'(int'(block_col_i) * OUT_BLOCK_WIDTH);
              fl_y0_d   = YW'(int'(block_row_i) * OUT_BLOCK_HEIGHT);
            end
            default: ;
          endcase
        end
      end
      ST_SET: begin
        if (pipe_empty) begin
          state_d = ST_IDLE;
        end
      end
      ST_DEC: begin
        dbit_d = dirty_rd[1];
        i_d    = '0;
        j_d    = '0;
        if (!fl_ok_q || dirty_rd == 2'b00) begin
          state_d = ST_SKIP;
        end else begin
          state_d = ST_STREAM;
        end
      end
      ST_SKIP: begin
        if (adv) begin
          state_d = ST_IDLE;
        end
      end
      ST_STREAM: begin
        if (adv) begin
          if (i_q == IW'(OUT_BLOCK_WIDTH - 1)) begin
            i_d = '0;
            j_d = j_q + JW'(1);
          end else begin
            i_d = i_q + IW'(1);
          end
          if (stream_last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      sw_q          <= '0;
      sweep_dirty_q <= 1'b1;
      sweep_dv_q    <= 1'b0;
      first_done_q  <= 1'b0;
    end else begin
      state_q       <= state_d;
      sw_q          <= sw_d;
      sweep_dirty_q <= sweep_dirty_d;
      sweep_dv_q    <= sweep_dv_d;
      first_done_q  <= first_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    j_q       <= j_d;
    fl_ok_q   <= fl_ok_d;
    fl_bidx_q <= fl_bidx_d;
    fl_x0_q   <= fl_x0_d;
    fl_y0_q   <= fl_y0_d;
    dbit_q    <= dbit_d;
  end

  // Load the output register from the read stage or a skipped flush
  always_comb begin
    out_valid_d = out_valid_q;
    pixel_d     = pixel_q;
    skipped_d   = skipped_q;
    last_d      = last_q;
    if (adv) begin
      out_valid_d = (v3_q && tag3_q.flush) || (state_q == ST_SKIP);
      if (state_q == ST_SKIP) begin
        pixel_d   = '0;
        skipped_d = 1'b1;
        last_d    = 1'b1;
      end else begin
        pixel_d   = out_color(front_rd ? color_rd[31:16] : color_rd[15:0]);
        skipped_d = 1'b0;
        last_d    = tag3_q.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q   <= pixel_d;
    skipped_q <= skipped_d;
    last_q    <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_out_o     = pixel_q;
  assign block_skipped_o = skipped_q;
  assign last_o          = last_q;

`ifndef NO_ASSERTIONS
  a_no_write_in_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) |-> !front_we && !color_we)
    else $error("memory write while a block streams");

  a_skip_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && block_skipped_o) |-> last_o)
    else $error("skipped result not marked last");

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> !in_ready_o)
    else $error("transaction accepted during fill pass");

  a_flush_in_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && tag3_q.flush) |-> (state_q == ST_STREAM || state_q == ST_DRAIN))
    else $error("flush pixel outside a flush");
`endif

endmodule
